// ----- src/evff_pkg.sv -----
`timescale 1ns / 1ps
package evff_pkg;

    // Sample and coordinate widths
    localparam int ELEV_W = 16;
    localparam int COL_W  = 12;
    localparam int TICK_W = COL_W + 1;
    localparam int ROW_LEN = 2 ** COL_W;

    // Raw store: slot, row of three, column. Filled store: slot, row of two, column.
    localparam int RAW_AW    = 1 + 2 + COL_W;
    localparam int FIL_AW    = 1 + 1 + COL_W;
    localparam int RAW_DEPTH = 2 * 4 * ROW_LEN;
    localparam int FIL_DEPTH = 2 * 2 * ROW_LEN;

    // Neighbour mean arithmetic
    localparam int CNT_W  = 4;
    localparam int ACC_W  = ELEV_W + 3;
    localparam int NUM_W  = ACC_W + 2;
    localparam int MAG_W  = NUM_W - 1;
    localparam int DCNT_W = 5;

    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_ELEV  = 1'b0,
        REG_TILE_SIDE = 1'b1
    } t_reg_idx;

    // Read phases of one fill window; name gives the raw-store read of that phase
    typedef enum logic [2:0] {
        PH_CUR_X  = 3'd0,
        PH_LEFT   = 3'd1,
        PH_DOWN_X = 3'd2,
        PH_DOWN_R = 3'd3,
        PH_DOWN_L = 3'd4
    } t_rd_phase;

    typedef struct packed {
        logic                     raw_we;
        logic [RAW_AW-1:0]        raw_waddr;
        logic signed [ELEV_W-1:0] raw_wdata;
        logic                     rd_en;
        t_rd_phase                rd_phase;
        logic                     res_slot;
        logic [COL_W-1:0]         res_row;
        logic [COL_W-1:0]         res_col;
        logic [COL_W-1:0]         res_side;
        logic [1:0]               res_i3;
        logic                     res_par;
        logic                     div_start;
        logic                     fin;
        logic                     last;
        logic signed [ELEV_W-1:0] min_elev;
    } t_dp_cmd;

    typedef struct packed {
        logic is_void;
        logic cnt_nz;
        logic div_busy;
        logic out_full;
    } t_dp_status;

endpackage

// ----- src/evff_in_if.sv -----
`timescale 1ns / 1ps
interface evff_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [evff_pkg::ELEV_W-1:0] elevation_in;
    logic                              tile_start;

    modport source (output valid, output elevation_in, output tile_start, input ready);
    modport sink (input valid, input elevation_in, input tile_start, output ready);
endinterface

// ----- src/evff_out_if.sv -----
`timescale 1ns / 1ps
interface evff_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [evff_pkg::ELEV_W-1:0] elevation_out;
    logic [evff_pkg::COL_W-1:0]         out_row;
    logic [evff_pkg::COL_W-1:0]         out_col;
    logic                              was_filled;
    logic                              last_of_run;

    modport source (output valid, output elevation_out, output out_row, output out_col,
                    output was_filled, output last_of_run, input ready);
    modport sink (input valid, input elevation_out, input out_row, input out_col,
                  input was_filled, input last_of_run, output ready);
endinterface

// ----- src/evff_cfg_if.sv -----
`timescale 1ns / 1ps
interface evff_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [evff_pkg::CFG_IDX_W-1:0]        index;
    logic [evff_pkg::ELEV_W-1:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/evff_ram.sv -----
`timescale 1ns / 1ps
module evff_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/evff_datapath.sv -----
`timescale 1ns / 1ps
module evff_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  evff_pkg::t_dp_cmd  i_cmd,
    output evff_pkg::t_dp_status o_stat,
    evff_out_if.source         o_result
);
    import evff_pkg::*;

    logic                     up, down, right, left;
    logic [COL_W-1:0]         xl, xr;
    logic [1:0]               i3_dn;
    logic [RAW_AW-1:0]        raw_raddr;
    logic [FIL_AW-1:0]        fil_raddr;
    logic [ELEV_W-1:0]        raw_q, fil_q;
    logic signed [ELEV_W-1:0] raw_d, fil_d, ref_bad;
    logic                     vr, vf, qr, qf;
    logic                     r_dv;
    t_rd_phase                r_dph;
    logic signed [ELEV_W-1:0] r_bad;
    logic signed [ACC_W-1:0]  r_acc, acc_base, add_r, add_f;
    logic [CNT_W-1:0]         r_cnt, cnt_base;
    logic                     r_nany;
    logic signed [NUM_W-1:0]  num;
    logic [NUM_W-1:0]         num_abs;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_neg;
    logic [CNT_W:0]           dvs;
    logic [CNT_W-1:0]         r_rem;
    logic [CNT_W:0]           rem_sh;
    logic [DCNT_W-1:0]        r_dcnt;
    logic signed [ELEV_W-1:0] quo, t_sel, val;
    logic                     is_void;
    logic                     r_ov;
    logic signed [ELEV_W-1:0] r_oelev;
    logic [COL_W-1:0]         r_orow, r_ocol;
    logic                     r_ofill, r_olast;

    // Window bounds and neighbour addresses
    assign up    = i_cmd.res_row < i_cmd.res_side;
    assign down  = i_cmd.res_row >= COL_W'(2);
    assign right = ({1'b0, i_cmd.res_col} + TICK_W'(1)) < {1'b0, i_cmd.res_side};
    assign left  = i_cmd.res_col != '0;
    assign xl    = i_cmd.res_col - COL_W'(1);
    assign xr    = i_cmd.res_col + COL_W'(1);
    assign i3_dn = (i_cmd.res_i3 == 2'd2) ? 2'd0 : i_cmd.res_i3 + 2'd1;

    always_comb begin
        raw_raddr = {i_cmd.res_slot, i_cmd.res_i3, i_cmd.res_col};
        fil_raddr = {i_cmd.res_slot, ~i_cmd.res_par, i_cmd.res_col};
        case (i_cmd.rd_phase)
            PH_CUR_X: begin
                raw_raddr = {i_cmd.res_slot, i_cmd.res_i3, i_cmd.res_col};
                fil_raddr = {i_cmd.res_slot, ~i_cmd.res_par, i_cmd.res_col};
            end
            PH_LEFT: begin
                raw_raddr = {i_cmd.res_slot, i_cmd.res_i3, xl};
                fil_raddr = {i_cmd.res_slot, ~i_cmd.res_par, xr};
            end
            PH_DOWN_X: begin
                raw_raddr = {i_cmd.res_slot, i3_dn, i_cmd.res_col};
                fil_raddr = {i_cmd.res_slot, ~i_cmd.res_par, xl};
            end
            PH_DOWN_R: begin
                raw_raddr = {i_cmd.res_slot, i3_dn, xr};
                fil_raddr = {i_cmd.res_slot, i_cmd.res_par, xr};
            end
            PH_DOWN_L: begin
                raw_raddr = {i_cmd.res_slot, i3_dn, xl};
                fil_raddr = {i_cmd.res_slot, i_cmd.res_par, xl};
            end
            default: begin
                raw_raddr = {i_cmd.res_slot, i_cmd.res_i3, i_cmd.res_col};
                fil_raddr = {i_cmd.res_slot, ~i_cmd.res_par, i_cmd.res_col};
            end
        endcase
    end

    evff_ram #(.WIDTH(ELEV_W), .DEPTH(RAW_DEPTH)) u_raw_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.raw_we),
        .i_waddr (i_cmd.raw_waddr),
        .i_wdata (i_cmd.raw_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (raw_raddr),
        .o_rdata (raw_q)
    );

    evff_ram #(.WIDTH(ELEV_W), .DEPTH(FIL_DEPTH)) u_fil_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fin),
        .i_waddr ({i_cmd.res_slot, i_cmd.res_par, i_cmd.res_col}),
        .i_wdata (val),
        .i_re    (i_cmd.rd_en),
        .i_raddr (fil_raddr),
        .o_rdata (fil_q)
    );

    assign raw_d = raw_q;
    assign fil_d = fil_q;

    // Which arriving words are in-bounds neighbours
    always_comb begin
        vr = 1'b0;
        vf = 1'b0;
        case (r_dph)
            PH_CUR_X:  begin vr = 1'b0;          vf = up;          end
            PH_LEFT:   begin vr = left;          vf = up & right;  end
            PH_DOWN_X: begin vr = down;          vf = up & left;   end
            PH_DOWN_R: begin vr = down & right;  vf = right;       end
            PH_DOWN_L: begin vr = down & left;   vf = 1'b0;        end
            default:   begin vr = 1'b0;          vf = 1'b0;        end
        endcase
    end

    // Keep only neighbours above the void's raw value
    assign ref_bad  = (r_dph == PH_CUR_X) ? raw_d : r_bad;
    assign qr       = vr && (raw_d > ref_bad);
    assign qf       = vf && (fil_d > ref_bad);
    assign acc_base = (r_dph == PH_CUR_X) ? '0 : r_acc;
    assign cnt_base = (r_dph == PH_CUR_X) ? '0 : r_cnt;
    assign add_r    = qr ? ACC_W'(raw_d) : '0;
    assign add_f    = qf ? ACC_W'(fil_d) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else begin
            r_dv <= i_cmd.rd_en;
        end
    end

    // Accumulate sum and count over the read phases
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_dph <= i_cmd.rd_phase;
        end
        if (r_dv) begin
            if (r_dph == PH_CUR_X) begin
                r_bad  <= raw_d;
                r_nany <= vf;
            end else begin
                r_nany <= r_nany | vr | vf;
            end
            r_acc <= acc_base + add_r + add_f;
            r_cnt <= cnt_base + CNT_W'(qr) + CNT_W'(qf);
        end
    end

    // Mean plus one half: (2A + C) / (2C), truncated toward zero
    assign num     = (NUM_W'(r_acc) <<< 1) + NUM_W'(r_cnt);
    assign num_abs = num[NUM_W-1] ? (NUM_W'(0) - num) : num;
    assign dvs     = {r_cnt, 1'b0};
    assign rem_sh  = {r_rem, r_mag[MAG_W-1]};

    // Restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_start) begin
            r_dcnt <= DCNT_W'(MAG_W);
        end else if (r_dcnt != '0) begin
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_mag <= num_abs[MAG_W-1:0];
            r_neg <= num[NUM_W-1];
            r_rem <= '0;
        end else if (r_dcnt != '0) begin
            if (rem_sh >= dvs) begin
                r_rem <= CNT_W'(rem_sh - dvs);
                r_mag <= {r_mag[MAG_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[CNT_W-1:0];
                r_mag <= {r_mag[MAG_W-2:0], 1'b0};
            end
        end
    end

    // Final value: original, or fill clamped up to the minimum
    assign is_void = r_bad < i_cmd.min_elev;
    assign quo     = r_neg ? (ELEV_W'(0) - r_mag[ELEV_W-1:0]) : r_mag[ELEV_W-1:0];

    always_comb begin
        if (r_cnt != '0) begin
            t_sel = quo;
        end else if (r_nany) begin
            t_sel = r_bad;
        end else begin
            t_sel = '0;
        end
        if (!is_void) begin
            val = r_bad;
        end else if (t_sel > i_cmd.min_elev) begin
            val = t_sel;
        end else begin
            val = i_cmd.min_elev;
        end
    end

    // Output register: hold until the result is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.fin) begin
            r_ov <= 1'b1;
        end else if (o_result.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_oelev <= val;
            r_orow  <= i_cmd.res_row;
            r_ocol  <= i_cmd.res_col;
            r_ofill <= is_void;
            r_olast <= i_cmd.last;
        end
    end

    assign o_result.valid         = r_ov;
    assign o_result.elevation_out = r_oelev;
    assign o_result.out_row       = r_orow;
    assign o_result.out_col       = r_ocol;
    assign o_result.was_filled    = r_ofill;
    assign o_result.last_of_run   = r_olast;

    assign o_stat.is_void  = is_void;
    assign o_stat.cnt_nz   = r_cnt != '0;
    assign o_stat.div_busy = r_dcnt != '0;
    assign o_stat.out_full = r_ov;
endmodule

// ----- src/evff_ctrl.sv -----
`timescale 1ns / 1ps
module evff_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    evff_in_if.sink              i_sample,
    evff_cfg_if.sink             i_cfg,
    input  evff_pkg::t_dp_status i_stat,
    output evff_pkg::t_dp_cmd    o_cmd
);
    import evff_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_CHECK,
        ST_DIV,
        ST_FIN
    } t_state;

    t_state                   r_state, n_state;
    t_rd_phase                r_phase, n_phase;
    logic signed [ELEV_W-1:0] r_min_elev, n_min_elev;
    logic [COL_W-1:0]         r_tile_side, n_tile_side;
    logic                     r_cur, n_cur;
    logic                     r_sel, n_sel;
    logic                     r_em_cur, n_em_cur;
    logic                     r_rcv, n_rcv;
    logic [COL_W-1:0]         r_in_row, n_in_row, r_in_col, n_in_col;
    logic [1:0]               r_in_i3, n_in_i3;
    logic                     r_live [2], n_live [2];
    logic [COL_W-1:0]         r_side [2], n_side [2];
    logic [TICK_W-1:0]        r_ticks [2], n_ticks [2];
    logic [COL_W-1:0]         r_orow [2], n_orow [2];
    logic [COL_W-1:0]         r_ocol [2], n_ocol [2];
    logic [1:0]               r_oi3 [2], n_oi3 [2];
    logic                     r_opar [2], n_opar [2];
    logic                     em [2];
    logic [TICK_W-1:0]        lim [2];
    logic [COL_W-1:0]         side_new;
    logic                     accept;
    t_dp_cmd                  cmd;

    assign accept      = i_sample.valid && i_sample.ready;
    assign i_sample.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign side_new    = (r_tile_side == '0) ? COL_W'(1) : r_tile_side;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_min_elev  = r_min_elev;
        n_tile_side = r_tile_side;
        n_cur       = r_cur;
        n_sel       = r_sel;
        n_em_cur    = r_em_cur;
        n_rcv       = r_rcv;
        n_in_row    = r_in_row;
        n_in_col    = r_in_col;
        n_in_i3     = r_in_i3;
        n_live      = r_live;
        n_side      = r_side;
        n_ticks     = r_ticks;
        n_orow      = r_orow;
        n_ocol      = r_ocol;
        n_oi3       = r_oi3;
        n_opar      = r_opar;
        for (int k = 0; k < 2; k++) begin
            em[k]  = 1'b0;
            lim[k] = '0;
        end

        cmd           = '0;
        cmd.rd_phase  = r_phase;
        cmd.res_slot  = r_sel;
        cmd.res_row   = r_orow[r_sel];
        cmd.res_col   = r_ocol[r_sel];
        cmd.res_side  = r_side[r_sel];
        cmd.res_i3    = r_oi3[r_sel];
        cmd.res_par   = r_opar[r_sel];
        cmd.min_elev  = r_min_elev;
        cmd.raw_wdata = i_sample.elevation_in;

        // Register writes
        if (i_cfg.valid) begin
            if (i_cfg.index == REG_MIN_ELEV) begin
                n_min_elev = i_cfg.data;
            end else begin
                n_tile_side = i_cfg.data[COL_W-1:0];
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    // Tile start: drop the older tile, abandon an unfinished one
                    if (i_sample.tile_start) begin
                        n_live[~r_cur] = 1'b0;
                        if (r_rcv) begin
                            n_live[r_cur] = 1'b0;
                        end
                        n_cur           = ~r_cur;
                        n_live[~r_cur]  = 1'b1;
                        n_side[~r_cur]  = side_new;
                        n_ticks[~r_cur] = '0;
                        n_orow[~r_cur]  = side_new;
                        n_ocol[~r_cur]  = side_new - COL_W'(1);
                        n_oi3[~r_cur]   = 2'd0;
                        n_opar[~r_cur]  = 1'b0;
                        n_rcv           = 1'b1;
                        n_in_row        = side_new;
                        n_in_col        = side_new - COL_W'(1);
                        n_in_i3         = 2'd0;
                    end
                    // Store the raw sample and advance the input position
                    if (n_rcv) begin
                        cmd.raw_we    = 1'b1;
                        cmd.raw_waddr = {n_cur, n_in_i3, n_in_col};
                        if (n_in_col == '0) begin
                            if (n_in_row == COL_W'(1)) begin
                                n_rcv = 1'b0;
                            end else begin
                                n_in_row = n_in_row - COL_W'(1);
                                n_in_col = n_side[n_cur] - COL_W'(1);
                                n_in_i3  = (n_in_i3 == 2'd2) ? 2'd0 : n_in_i3 + 2'd1;
                            end
                        end else begin
                            n_in_col = n_in_col - COL_W'(1);
                        end
                    end
                    // Count steps per live tile; results flow once the lag is met
                    for (int k = 0; k < 2; k++) begin
                        lim[k] = {1'b0, n_side[k]} + TICK_W'(2);
                        if (n_live[k] && (n_ticks[k] < lim[k])) begin
                            n_ticks[k] = n_ticks[k] + TICK_W'(1);
                        end
                        em[k] = n_live[k] && (n_ticks[k] >= lim[k]);
                    end
                    n_em_cur = em[n_cur];
                    n_phase  = PH_CUR_X;
                    if (em[~n_cur]) begin
                        n_sel   = ~n_cur;
                        n_state = ST_READ;
                    end else if (em[n_cur]) begin
                        n_sel   = n_cur;
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.rd_en = 1'b1;
                if (r_phase == PH_DOWN_L) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_phase = t_rd_phase'(r_phase + 3'd1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_stat.is_void && i_stat.cnt_nz) begin
                    cmd.div_start = 1'b1;
                    n_state       = ST_DIV;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!i_stat.out_full) begin
                    cmd.fin  = 1'b1;
                    cmd.last = (r_sel != r_cur) ? !r_em_cur : 1'b1;
                    // Advance the output position of this tile
                    if (r_ocol[r_sel] == '0) begin
                        if (r_orow[r_sel] == COL_W'(1)) begin
                            n_live[r_sel] = 1'b0;
                        end else begin
                            n_orow[r_sel] = r_orow[r_sel] - COL_W'(1);
                            n_ocol[r_sel] = r_side[r_sel] - COL_W'(1);
                            n_oi3[r_sel]  = (r_oi3[r_sel] == 2'd2) ? 2'd0
                                                                  : r_oi3[r_sel] + 2'd1;
                            n_opar[r_sel] = ~r_opar[r_sel];
                        end
                    end else begin
                        n_ocol[r_sel] = r_ocol[r_sel] - COL_W'(1);
                    end
                    if ((r_sel != r_cur) && r_em_cur) begin
                        n_sel   = r_cur;
                        n_phase = PH_CUR_X;
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_CUR_X;
            r_min_elev  <= '0;
            r_tile_side <= COL_W'(1200);
            r_cur       <= 1'b0;
            r_sel       <= 1'b0;
            r_em_cur    <= 1'b0;
            r_rcv       <= 1'b0;
            r_in_row    <= '0;
            r_in_col    <= '0;
            r_in_i3     <= '0;
            for (int k = 0; k < 2; k++) begin
                r_live[k]  <= 1'b0;
                r_side[k]  <= '0;
                r_ticks[k] <= '0;
                r_orow[k]  <= '0;
                r_ocol[k]  <= '0;
                r_oi3[k]   <= '0;
                r_opar[k]  <= 1'b0;
            end
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_min_elev  <= n_min_elev;
            r_tile_side <= n_tile_side;
            r_cur       <= n_cur;
            r_sel       <= n_sel;
            r_em_cur    <= n_em_cur;
            r_rcv       <= n_rcv;
            r_in_row    <= n_in_row;
            r_in_col    <= n_in_col;
            r_in_i3     <= n_in_i3;
            r_live      <= n_live;
            r_side      <= n_side;
            r_ticks     <= n_ticks;
            r_orow      <= n_orow;
            r_ocol      <= n_ocol;
            r_oi3       <= n_oi3;
            r_opar      <= n_opar;
        end
    end

    assign o_cmd = cmd;
endmodule

// ----- src/elevation_void_fill_filter.sv -----
`timescale 1ns / 1ps
// Void-filling filter for a square elevation tile, streamed rows top to bottom
// and columns right to left. Each result trails its request by side+1 items;
// a request causes zero, one or two results (two when an old tile drains while
// a new one starts). No new request is taken while results are formed. Each
// result takes five reads of the raw and filled row memories (one read port
// each), a check, a divide on the one-bit-per-cycle mean divider when the
// sample is a void with greater neighbours, and write-back. Stores need no
// clearing pass: every window entry read was written earlier in the same tile.
module elevation_void_fill_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    evff_in_if.sink    i_sample,
    evff_out_if.source o_result,
    evff_cfg_if.sink   i_cfg
);
    import evff_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status stat;

    evff_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample),
        .i_cfg    (i_cfg),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    evff_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result)
    );

    // Result write-back only into a free output register
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fin |-> !stat.out_full)
        else $error("result formed while output register full");

    // Divider runs after a start
    a_div_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |=> stat.div_busy)
        else $error("divider did not start");

    // Raw store written only by an accepted request
    a_raw_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.raw_we |-> (i_sample.valid && i_sample.ready))
        else $error("raw store written without request");

    // No new request while a mean is computed
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.div_busy |-> !i_sample.ready)
        else $error("request taken during divide");
endmodule
